### design/prd_pkg.sv
`default_nettype none

package prd_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int DEF_CMD_FIFO_DEPTH  = 4;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LINE_PITCH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_IMAGE_ROWS  = 2'd2;

  localparam logic [CFG_DW-1:0] DIM_RESET = 16'd256;

  localparam logic [1:0] REQ_STREAM  = 2'd0;
  localparam logic [1:0] REQ_PALETTE = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;

  localparam logic [7:0] RUN_MARK          = 8'hc0;
  localparam logic [7:0] INDEX_TRANSPARENT = 8'hff;
  localparam logic [7:0] ALPHA_OPAQUE      = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR       = 8'h00;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_PALETTE = 2'd1,
    CMD_START   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } prd_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic       image_done;
  } prd_out_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       run_hdr;
    logic [5:0] run_len;
    logic [7:0] value;
    logic [7:0] pal_index;
    logic [23:0] pal_rgb;
  } prd_cmd_t;

endpackage

`default_nettype wire

### design/prd_front.sv
`default_nettype none

module prd_front
  import prd_pkg::*;
(
  input  wire logic     in_valid,
  input  wire prd_in_t  in_data,
  output logic          in_ready,
  input  wire logic     fifo_full,
  output logic          fifo_push,
  output prd_cmd_t      fifo_cmd
);

  logic known;

  always_comb begin
    fifo_cmd           = '0;
    known              = 1'b1;
    fifo_cmd.value     = in_data.data_byte;
    fifo_cmd.run_hdr   = ((in_data.data_byte & RUN_MARK) == RUN_MARK);
    fifo_cmd.run_len   = in_data.data_byte[5:0];
    fifo_cmd.pal_index = in_data.palette_index;
    fifo_cmd.pal_rgb   = {in_data.palette_red, in_data.palette_green, in_data.palette_blue};
    case (in_data.req_type)
      REQ_STREAM:  fifo_cmd.kind = CMD_BYTE;
      REQ_PALETTE: fifo_cmd.kind = CMD_PALETTE;
      REQ_START:   fifo_cmd.kind = CMD_START;
      default: begin
        fifo_cmd.kind = CMD_BYTE;
        known         = 1'b0;
      end
    endcase
  end

  // unused request codes are taken and dropped here
  assign in_ready  = !fifo_full;
  assign fifo_push = in_valid && !fifo_full && known;

endmodule

`default_nettype wire

### design/prd_cmd_fifo.sv
`default_nettype none

module prd_cmd_fifo
  import prd_pkg::*;
#(
  parameter int DEPTH = DEF_CMD_FIFO_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire prd_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          pop_valid,
  output prd_cmd_t      pop_cmd
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  prd_cmd_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### design/prd_back.sv
`default_nettype none

module prd_back
  import prd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire prd_cmd_t          cmd,
  output logic                   cmd_pop,
  input  wire logic [CFG_DW-1:0] image_width,
  input  wire logic [CFG_DW-1:0] line_pitch,
  input  wire logic [CFG_DW-1:0] image_rows,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prd_out_t               out_data
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic          run_pend_r, run_pend_nxt;
  logic [5:0]    pend_cnt_r, pend_cnt_nxt;
  logic [15:0]   col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic          done_r, done_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [5:0]    rem_r, rem_nxt;
  logic          held_r, held_nxt;
  logic          fin_r, fin_nxt;

  logic [23:0]   pal_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_vld_r;
  logic          pal_we;

  logic          ov_r;
  logic [7:0]    o_idx_r;
  logic          o_last_r, o_done_r, o_pv_r;
  logic [23:0]   o_rgb_r;

  logic          st_free, visible, row_end, img_end, fin_now, final_step;
  logic          push, push_last, push_done;
  logic [16:0]   col_p1, row_p1;

  assign st_free    = !ov_r || out_ready;
  assign visible    = (col_r < image_width);
  assign col_p1     = {1'b0, col_r} + 17'd1;
  assign row_p1     = {1'b0, row_r} + 17'd1;
  assign row_end    = (col_p1 >= {1'b0, line_pitch});
  assign img_end    = row_end && (row_p1 >= {1'b0, image_rows});
  assign fin_now    = fin_r || img_end;
  assign final_step = (rem_r == 6'd1) || img_end;

  always_comb begin
    state_nxt    = state_r;
    run_pend_nxt = run_pend_r;
    pend_cnt_nxt = pend_cnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    done_nxt     = done_r;
    val_nxt      = val_r;
    rem_nxt      = rem_r;
    held_nxt     = held_r;
    fin_nxt      = fin_r;
    cmd_pop      = 1'b0;
    pal_we       = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    push_done    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_PALETTE: pal_we = 1'b1;
            CMD_START: begin
              run_pend_nxt = 1'b0;
              pend_cnt_nxt = '0;
              col_nxt      = '0;
              row_nxt      = '0;
              done_nxt     = 1'b0;
            end
            CMD_BYTE: begin
              if (!done_r) begin
                held_nxt = 1'b0;
                fin_nxt  = 1'b0;
                val_nxt  = cmd.value;
                if (run_pend_r) begin
                  run_pend_nxt = 1'b0;
                  pend_cnt_nxt = '0;
                  rem_nxt      = pend_cnt_r;
                  if (pend_cnt_r != '0) begin
                    state_nxt = ST_RUN;
                  end
                end else if (cmd.run_hdr) begin
                  run_pend_nxt = 1'b1;
                  pend_cnt_nxt = cmd.run_len;
                end else begin
                  rem_nxt   = 6'd1;
                  state_nxt = ST_RUN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (st_free) begin
          if (row_end) begin
            col_nxt = '0;
            if (img_end) begin
              done_nxt = 1'b1;
            end else begin
              row_nxt = row_r + 16'd1;
            end
          end else begin
            col_nxt = col_r + 16'd1;
          end
          rem_nxt = rem_r - 6'd1;
          fin_nxt = fin_now;
          if (!final_step) begin
            if (visible) begin
              push     = held_r;
              held_nxt = 1'b1;
            end
          end else if (visible && held_r) begin
            push      = 1'b1;
            held_nxt  = 1'b1;
            state_nxt = ST_FLUSH;
          end else begin
            push      = visible || held_r;
            push_last = 1'b1;
            push_done = fin_now;
            held_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (st_free) begin
          push      = held_r;
          push_last = 1'b1;
          push_done = fin_r;
          held_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      run_pend_r <= 1'b0;
      pend_cnt_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      done_r     <= 1'b0;
      held_r     <= 1'b0;
      fin_r      <= 1'b0;
      ov_r       <= 1'b0;
      pal_vld_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      run_pend_r <= run_pend_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      done_r     <= done_nxt;
      held_r     <= held_nxt;
      fin_r      <= fin_nxt;
      if (push) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (pal_we) begin
        pal_vld_r[cmd.pal_index[PAL_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    if (pal_we) begin
      pal_mem[cmd.pal_index[PAL_AW-1:0]] <= cmd.pal_rgb;
    end
    if (push) begin
      o_rgb_r  <= pal_mem[val_r[PAL_AW-1:0]];
      o_pv_r   <= pal_vld_r[val_r[PAL_AW-1:0]];
      o_idx_r  <= val_r;
      o_last_r <= push_last;
      o_done_r <= push_done;
    end
  end

  // entries never written read as the grayscale ramp
  always_comb begin
    if (o_pv_r) begin
      {out_data.red, out_data.green, out_data.blue} = o_rgb_r;
    end else begin
      {out_data.red, out_data.green, out_data.blue} = {o_idx_r, o_idx_r, o_idx_r};
    end
    out_data.alpha      = (o_idx_r == INDEX_TRANSPARENT) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    out_data.last       = o_last_r;
    out_data.image_done = o_done_r;
  end

  assign out_valid = ov_r;

endmodule

`default_nettype wire

### design/pcx_rle_palette_decoder.sv
// 8-bit PCX run-length decoder with palette lookup, giving RGBA pixels.
// in_*: valid/ready channel of requests: an encoded stream byte, a palette
//   entry write or a start of image. Requests go into a command queue, so
//   in_ready only drops while that queue is full.
// out_*: valid/ready channel of pixels; last marks the final pixel of one
//   request, image_done the pixel that completes the image.
// cfg_*: write port for the image width, line pitch and row count; it is to be
//   written only while the decoder is idle, which the block does not enforce.
// A literal byte passes the command queue and engine state to the output.
// Throughput: the decoding engine takes one command per cycle in its idle
//   state, which palette writes, starts and run headers never leave; a
//   literal byte or run leaves it, and no command is taken until all of
//   its pixels have entered the one-pixel-per-cycle output register.
// A stalled receiver holds the output register, which halts the engine;
//   input transfers continue until the command queue fills.
// Reset: the palette reads as the grayscale ramp at once, the dimension
//   registers return to 256 and row, column and pending-run state clears.
`default_nettype none

module pcx_rle_palette_decoder
  import prd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
  parameter int CMD_FIFO_DEPTH  = DEF_CMD_FIFO_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire prd_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prd_out_t               out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  logic [CFG_DW-1:0] width_r, bpl_r, rows_r;
  logic              fifo_full, fifo_push, fifo_valid, fifo_pop;
  prd_cmd_t          push_cmd, pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= DIM_RESET;
      bpl_r   <= DIM_RESET;
      rows_r  <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: width_r <= cfg_wdata;
        REG_LINE_PITCH:  bpl_r   <= cfg_wdata;
        REG_IMAGE_ROWS:  rows_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  prd_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .fifo_full (fifo_full),
    .fifo_push (fifo_push),
    .fifo_cmd  (push_cmd)
  );

  prd_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_valid (fifo_valid),
    .pop_cmd   (pop_cmd)
  );

  prd_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (fifo_valid),
    .cmd         (pop_cmd),
    .cmd_pop     (fifo_pop),
    .image_width (width_r),
    .line_pitch  (bpl_r),
    .image_rows  (rows_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_done |-> out_data.last)
    else $error("image_done without last");

  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alpha == ALPHA_CLEAR || out_data.alpha == ALPHA_OPAQUE))
    else $error("alpha not clear or opaque");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel valid after reset");

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prd_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  prd_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  prd_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  pcx_rle_palette_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // decoder state as the pixels should see it
  logic [7:0] pal_r [256];
  logic [7:0] pal_g [256];
  logic [7:0] pal_b [256];
  logic run_armed;
  logic [5:0] run_len;
  logic [15:0] col_pos;
  logic [15:0] row_pos;
  logic img_done;
  logic [15:0] width_reg;
  logic [15:0] pitch_reg;
  logic [15:0] rows_reg;

  prd_in_t pending_items[$];
  prd_out_t expected_pixels[$];
  int items_queued = 0;
  int items_taken = 0;
  int fail_count = 0;

  logic steady = 1'b0;
  logic hold_arm = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  prd_out_t want;

  function automatic bit store_byte(input logic [7:0] idx, output prd_out_t px);
    bit vis;
    vis = col_pos < width_reg;
    px = '0;
    px.red = pal_r[idx];
    px.green = pal_g[idx];
    px.blue = pal_b[idx];
    px.alpha = (idx == INDEX_TRANSPARENT) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    if (int'(col_pos) + 1 >= int'(pitch_reg) || col_pos == 16'hffff) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= int'(rows_reg) || row_pos == 16'hffff) begin
        img_done = 1'b1;
      end else begin
        row_pos = row_pos + 16'd1;
      end
    end else begin
      col_pos = col_pos + 16'd1;
    end
    return vis;
  endfunction

  task automatic expand_run(input logic [7:0] value, input int count);
    prd_out_t px;
    prd_out_t held;
    bit have_held;
    bit finished;
    have_held = 1'b0;
    finished = 1'b0;
    held = '0;
    for (int i = 0; i < count && !img_done; i++) begin
      if (store_byte(value, px)) begin
        if (have_held) expected_pixels.push_back(held);
        held = px;
        have_held = 1'b1;
      end
      if (img_done) finished = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      held.image_done = finished;
      expected_pixels.push_back(held);
    end
  endtask

  task automatic predict_request(input prd_in_t rq);
    int cnt;
    case (rq.req_type)
      REQ_PALETTE: begin
        pal_r[rq.palette_index] = rq.palette_red;
        pal_g[rq.palette_index] = rq.palette_green;
        pal_b[rq.palette_index] = rq.palette_blue;
      end
      REQ_START: begin
        run_armed = 1'b0;
        run_len = '0;
        col_pos = '0;
        row_pos = '0;
        img_done = 1'b0;
      end
      REQ_STREAM: begin
        if (!img_done) begin
          if (run_armed) begin
            cnt = run_len;
            run_armed = 1'b0;
            run_len = '0;
            expand_run(rq.data_byte, cnt);
          end else if ((rq.data_byte & RUN_MARK) == RUN_MARK) begin
            run_armed = 1'b1;
            run_len = rq.data_byte[5:0];
          end else begin
            expand_run(rq.data_byte, 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: pixel transfer expected none got %p", $time, out_data);
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, out_data.red);
          check_field("green", want.green, out_data.green);
          check_field("blue", want.blue, out_data.blue);
          check_field("alpha", want.alpha, out_data.alpha);
          check_field("last", 8'(want.last), 8'(out_data.last));
          check_field("image_done", 8'(want.image_done), 8'(out_data.image_done));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 22);
      end
    end
  end

  task automatic push_req(input logic [1:0] kind, input logic [7:0] b, pi, r, g, bl);
    prd_in_t rq;
    rq.req_type = kind;
    rq.data_byte = b;
    rq.palette_index = pi;
    rq.palette_red = r;
    rq.palette_green = g;
    rq.palette_blue = bl;
    pending_items.push_back(rq);
    items_queued++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_req(REQ_STREAM, b, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic push_start();
    push_req(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom));
  endtask

  task automatic set_dim(input logic [CFG_AW-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: width_reg = val;
      REG_LINE_PITCH: pitch_reg = val;
      REG_IMAGE_ROWS: rows_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_image(input logic [15:0] w, input logic [15:0] p, input logic [15:0] r);
    set_dim(REG_IMAGE_WIDTH, w);
    set_dim(REG_LINE_PITCH, p);
    set_dim(REG_IMAGE_ROWS, r);
  endtask

  // wait for every transfer and pixel, then let silent commands drain
  task automatic settle();
    @(posedge clk);
    while (items_taken != items_queued || expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // images: a start, then encoded bytes, palette writes and unused requests up to a byte goal
  task automatic random_images(input int count);
    int made;
    int filled;
    longint goal;
    int len;
    int pick;
    made = 0;
    while (made < count) begin
      push_start();
      made++;
      goal = longint'(pitch_reg) * longint'(rows_reg);
      if (goal > 80) goal = $urandom_range(20, 80);
      filled = 0;
      while (filled < goal && made < count) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          push_byte(8'($urandom_range(0, 191)));
          filled++;
          made++;
        end else if (pick < 75) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
          push_byte(RUN_MARK | 8'(len));
          push_byte(($urandom_range(7) == 0) ? INDEX_TRANSPARENT : 8'($urandom));
          filled += len;
          made += 2;
        end else if (pick < 87) begin
          push_req(REQ_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
          made++;
        end else if (pick < 91) begin
          push_req(REQ_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
          made++;
        end else if (pick < 94) begin
          // header left dangling, taken by a trailing byte or cleared by the next start
          push_byte(RUN_MARK | 8'($urandom_range(0, 63)));
          made++;
          filled = int'(goal);
        end else begin
          push_byte(8'($urandom));
          filled++;
          made++;
        end
      end
      if ($urandom_range(3) == 0) begin
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        made += 2;
      end
    end
  endtask

  initial begin
    logic [15:0] w;
    for (int i = 0; i < 256; i++) begin
      pal_r[i] = 8'(i);
      pal_g[i] = 8'(i);
      pal_b[i] = 8'(i);
    end
    run_armed = 1'b0;
    run_len = '0;
    col_pos = '0;
    row_pos = '0;
    img_done = 1'b0;
    width_reg = DIM_RESET;
    pitch_reg = DIM_RESET;
    rows_reg = DIM_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // grayscale ramp and literal extremes
    push_byte(8'h00);
    push_byte(8'hbf);
    push_byte(8'h3f);
    // longest run of the transparent index
    push_byte(8'hff);
    push_byte(8'hff);
    // empty run
    push_byte(8'hc0);
    push_byte(8'h55);
    // run value that looks like a header
    push_byte(8'hc2);
    push_byte(8'hc1);
    push_req(REQ_PALETTE, 8'h00, 8'h12, 8'hff, 8'h00, 8'ha5);
    push_byte(8'h12);
    push_req(REQ_PALETTE, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff);
    push_byte(8'h00);
    push_req(REQ_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    // start drops a pending header
    push_byte(8'hc5);
    push_start();
    push_byte(8'h07);
    settle();

    set_image(16'd4, 16'd6, 16'd2);
    // run that fills the image exactly, then bytes after the end
    push_start();
    push_byte(8'hcc);
    push_byte(8'h30);
    push_byte(8'h01);
    push_byte(8'hc3);
    push_byte(8'h02);
    // run past the end of the image
    push_start();
    push_byte(8'hd0);
    push_byte(8'h09);
    // image completed by padding only
    push_start();
    push_byte(8'hca);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    push_byte(8'h44);
    settle();

    set_image(16'd3, 16'd5, 16'd2);
    random_images(70);
    settle();

    set_image(16'd8, 16'd8, 16'd4);
    hold_arm <= 1'b1;
    random_images(60);
    settle();

    w = 16'($urandom_range(1, 8));
    set_image(w, w + 16'($urandom_range(0, 3)), 16'($urandom_range(1, 6)));
    steady <= 1'b1;
    random_images(80);
    settle();
    steady <= 1'b0;

    set_image(16'hffff, 16'd1, 16'hffff);
    random_images(50);
    settle();

    set_image(16'd1, 16'd1, 16'd1);
    random_images(50);
    settle();

    set_image(16'($urandom_range(1, 65535)), 16'hffff, 16'hffff);
    random_images(30);
    settle();

    repeat (3) begin
      w = 16'($urandom_range(1, 10));
      set_image(w, w + 16'($urandom_range(0, 3)), 16'($urandom_range(1, 5)));
      random_images(30);
      settle();
    end

    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb: errors");
    $finish;
  end

endmodule

### sim.f
design/prd_pkg.sv
design/prd_front.sv
design/prd_cmd_fifo.sv
design/prd_back.sv
design/pcx_rle_palette_decoder.sv
tb/tb.sv
